@@ sv/running_min_max_mean_stddev_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the round-trip-time statistics block
// Shorthand for clocked implication checks with a synchronous low reset.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MIN_MAX_MEAN_STDDEV_MACROS_SVH
`define RUNNING_MIN_MAX_MEAN_STDDEV_MACROS_SVH

// same-cycle implication
`define RMMMS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("rmmms same-cycle check failed");

// next-cycle implication
`define RMMMS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("rmmms next-cycle check failed");

`endif

@@ sv/rmmms_pkg.sv @@
// ----------------------------------------------------------------------------
// rmmms_pkg
// Command codes shared by the statistics block and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rmmms_pkg;

  localparam int MODE_W = 2;

  // command carried with each input beat; the fourth code is ignored
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_REPORT = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_t;

endpackage

`default_nettype wire

@@ sv/running_min_max_mean_stddev.sv @@
// ----------------------------------------------------------------------------
// running_min_max_mean_stddev
// Round-trip-time statistics: min, max, mean and deviation in microseconds.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken when start is high and busy is low. in_mode picks
//   add (sample), report or clear. Negative samples, adds once the count is
//   full, reports with no samples and the unused code do nothing.
//   A report gives one result beat, marked by out_valid for a single cycle;
//   the receiver has no way to hold it off and must take it then.
// Sequencing:
//   clear, ignored beats: done at the accepting edge, busy stays low.
//   add: busy while the square is formed one multiplier bit per cycle
//     into the sum of squares.
//   report: busy through a radix-2 divide of both sums by the count, a
//     bit-serial square of the average and a two-bit-per-step square root.
//     out_valid rises in the same cycle that busy falls; a new beat may be
//     taken then.
// Reset: synchronous, active low; all accumulators and the count go to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module running_min_max_mean_stddev
  import rmmms_pkg::*;
#(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [MODE_W-1:0]             in_mode,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_us,
  output logic                               out_valid,
  output logic [SAMPLE_BITS-2:0]             out_min_us,
  output logic [SAMPLE_BITS-2:0]             out_avg_us,
  output logic [SAMPLE_BITS-2:0]             out_max_us,
  output logic [SAMPLE_BITS-2:0]             out_mdev_us,
  output logic [COUNT_BITS-1:0]              out_sample_count
);

  localparam int VAL_W  = SAMPLE_BITS - 1;
  localparam int PROD_W = 2 * VAL_W;
  localparam int TOT_W  = SAMPLE_BITS + COUNT_BITS;
  localparam int SQ_W   = 2 * SAMPLE_BITS + COUNT_BITS - 1;
  localparam int CNT_W  = $clog2(SQ_W);
  localparam int RT_W   = VAL_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_DIV,
    ST_AVSQ,
    ST_VAR,
    ST_ROOT
  } state_t;

  state_t                 state_r;
  logic [VAL_W-1:0]       lowest_r;
  logic [VAL_W-1:0]       highest_r;
  logic [TOT_W-1:0]       total_r;
  logic [SQ_W-1:0]        tsq_r;
  logic [COUNT_BITS-1:0]  accepted_r;

  // shared shift-add multiplier
  logic [VAL_W-1:0]       mplier_r;
  logic [PROD_W-1:0]      mcand_r;
  logic [PROD_W-1:0]      sq_r;

  // two restoring dividers running side by side
  logic [COUNT_BITS-1:0]  rt_r;
  logic [SQ_W-1:0]        qt_r;
  logic [COUNT_BITS-1:0]  rs_r;
  logic [SQ_W-1:0]        qs_r;
  logic [CNT_W-1:0]       cnt_r;

  // square root
  logic [PROD_W-1:0]      rad_r;
  logic [RT_W-1:0]        rrem_r;
  logic [VAL_W-1:0]       root_r;

  logic                   out_valid_r;
  logic [VAL_W-1:0]       out_min_r;
  logic [VAL_W-1:0]       out_avg_r;
  logic [VAL_W-1:0]       out_max_r;
  logic [VAL_W-1:0]       out_mdev_r;
  logic [COUNT_BITS-1:0]  out_cnt_r;

  logic                   smp_neg;
  logic [VAL_W-1:0]       smp_val;
  logic                   cnt_full;
  logic [COUNT_BITS:0]    div_ext;
  logic [COUNT_BITS:0]    t_trial;
  logic [COUNT_BITS:0]    t_diff;
  logic                   t_ge;
  logic [COUNT_BITS-1:0]  rt_nxt;
  logic [SQ_W-1:0]        qt_nxt;
  logic [COUNT_BITS:0]    s_trial;
  logic [COUNT_BITS:0]    s_diff;
  logic                   s_ge;
  logic [COUNT_BITS-1:0]  rs_nxt;
  logic [SQ_W-1:0]        qs_nxt;
  logic [PROD_W-1:0]      msq;
  logic [PROD_W-1:0]      var_val;
  logic [RT_W+1:0]        r_trial;
  logic [RT_W+1:0]        r_cand;
  logic [RT_W+1:0]        r_diff;
  logic                   r_ge;
  logic [RT_W-1:0]        rrem_nxt;
  logic [VAL_W-1:0]       root_nxt;

  assign busy = (state_r != ST_IDLE);

  // incoming sample split
  assign smp_neg  = in_sample_us[SAMPLE_BITS-1];
  assign smp_val  = in_sample_us[VAL_W-1:0];
  assign cnt_full = (accepted_r == {COUNT_BITS{1'b1}});

  // one quotient bit per cycle for both sums
  always_comb begin
    div_ext = {1'b0, accepted_r};
    t_trial = {rt_r, qt_r[SQ_W-1]};
    t_diff  = t_trial - div_ext;
    t_ge    = (t_trial >= div_ext);
    rt_nxt  = t_ge ? t_diff[COUNT_BITS-1:0] : t_trial[COUNT_BITS-1:0];
    qt_nxt  = {qt_r[SQ_W-2:0], t_ge};
    s_trial = {rs_r, qs_r[SQ_W-1]};
    s_diff  = s_trial - div_ext;
    s_ge    = (s_trial >= div_ext);
    rs_nxt  = s_ge ? s_diff[COUNT_BITS-1:0] : s_trial[COUNT_BITS-1:0];
    qs_nxt  = {qs_r[SQ_W-2:0], s_ge};
  end

  // clamped variance: mean square minus squared mean
  assign msq     = qs_r[PROD_W-1:0];
  assign var_val = (msq > sq_r) ? (msq - sq_r) : '0;

  // two radicand bits per root step
  always_comb begin
    r_trial  = {rrem_r, rad_r[PROD_W-1 -: 2]};
    r_cand   = {1'b0, root_r, 2'b01};
    r_diff   = r_trial - r_cand;
    r_ge     = (r_trial >= r_cand);
    rrem_nxt = r_ge ? r_diff[RT_W-1:0] : r_trial[RT_W-1:0];
    root_nxt = {root_r[VAL_W-2:0], r_ge};
  end

  // sequencer, accumulators and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      lowest_r    <= '0;
      highest_r   <= '0;
      total_r     <= '0;
      tsq_r       <= '0;
      accepted_r  <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            priority if (in_mode == MODE_ADD) begin
              if (!smp_neg && !cnt_full) begin
                if (accepted_r == '0) begin
                  lowest_r  <= smp_val;
                  highest_r <= smp_val;
                end else begin
                  if (smp_val < lowest_r) lowest_r <= smp_val;
                  if (smp_val > highest_r) highest_r <= smp_val;
                end
                total_r    <= total_r + TOT_W'(smp_val);
                accepted_r <= accepted_r + 1'b1;
                mplier_r   <= smp_val;
                mcand_r    <= PROD_W'(smp_val);
                state_r    <= ST_SQR;
              end
            end else if (in_mode == MODE_REPORT) begin
              if (accepted_r != '0) begin
                rt_r    <= '0;
                qt_r    <= SQ_W'(total_r);
                rs_r    <= '0;
                qs_r    <= tsq_r;
                cnt_r   <= CNT_W'(SQ_W - 1);
                state_r <= ST_DIV;
              end
            end else if (in_mode == MODE_CLEAR) begin
              lowest_r   <= '0;
              highest_r  <= '0;
              total_r    <= '0;
              tsq_r      <= '0;
              accepted_r <= '0;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end

        // square of the new sample into the sum of squares
        ST_SQR: begin
          if (mplier_r[0]) tsq_r <= tsq_r + SQ_W'(mcand_r);
          mplier_r <= mplier_r >> 1;
          mcand_r  <= mcand_r << 1;
          if ((mplier_r >> 1) == '0) state_r <= ST_IDLE;
        end

        ST_DIV: begin
          rt_r  <= rt_nxt;
          qt_r  <= qt_nxt;
          rs_r  <= rs_nxt;
          qs_r  <= qs_nxt;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            mplier_r <= qt_nxt[VAL_W-1:0];
            mcand_r  <= PROD_W'(qt_nxt[VAL_W-1:0]);
            sq_r     <= '0;
            state_r  <= ST_AVSQ;
          end
        end

        // average squared
        ST_AVSQ: begin
          if (mplier_r[0]) sq_r <= sq_r + mcand_r;
          mplier_r <= mplier_r >> 1;
          mcand_r  <= mcand_r << 1;
          if ((mplier_r >> 1) == '0) state_r <= ST_VAR;
        end

        ST_VAR: begin
          rad_r   <= var_val;
          rrem_r  <= '0;
          root_r  <= '0;
          cnt_r   <= CNT_W'(VAL_W - 1);
          state_r <= ST_ROOT;
        end

        ST_ROOT: begin
          rrem_r <= rrem_nxt;
          root_r <= root_nxt;
          rad_r  <= rad_r << 2;
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            out_min_r   <= lowest_r;
            out_avg_r   <= qt_r[VAL_W-1:0];
            out_max_r   <= highest_r;
            out_mdev_r  <= root_nxt;
            out_cnt_r   <= accepted_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_min_us       = out_min_r;
  assign out_avg_us       = out_avg_r;
  assign out_max_us       = out_max_r;
  assign out_mdev_us      = out_mdev_r;
  assign out_sample_count = out_cnt_r;

endmodule

`default_nettype wire

@@ sv/rmmms_chk.sv @@
// ----------------------------------------------------------------------------
// rmmms_chk
// Port-level checks on the statistics block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "running_min_max_mean_stddev_macros.svh"

module rmmms_chk
  import rmmms_pkg::*;
#(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS  = 16
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic [MODE_W-1:0]      in_mode,
  input wire logic                   out_valid,
  input wire logic [SAMPLE_BITS-2:0] out_min_us,
  input wire logic [SAMPLE_BITS-2:0] out_avg_us,
  input wire logic [SAMPLE_BITS-2:0] out_max_us,
  input wire logic [COUNT_BITS-1:0]  out_sample_count
);

  logic avg_in_range;
  logic report_taken;

  assign avg_in_range = (out_min_us <= out_avg_us) && (out_avg_us <= out_max_us);
  assign report_taken = start && !busy && (in_mode == MODE_REPORT);

  // a report beat never comes back with an empty count
  `RMMMS_ASSERT_IMP(a_cnt_nonzero, clk, rst_n, out_valid, out_sample_count != '0)

  // floor of the mean lies between the extremes
  `RMMMS_ASSERT_IMP(a_avg_order, clk, rst_n, out_valid, avg_in_range)

  // no command beat, report included, answers in the very next cycle
  `RMMMS_ASSERT_NXT(a_no_fast_result, clk, rst_n, start && !busy, !out_valid)

  // a report taken while out_valid is up gives no result beat straight after
  `RMMMS_ASSERT_NXT(a_report_busy, clk, rst_n, report_taken && out_valid, !out_valid)

endmodule

bind running_min_max_mean_stddev rmmms_chk #(
  .SAMPLE_BITS(SAMPLE_BITS),
  .COUNT_BITS (COUNT_BITS)
) u_rmmms_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_mode         (in_mode),
  .out_valid       (out_valid),
  .out_min_us      (out_min_us),
  .out_avg_us      (out_avg_us),
  .out_max_us      (out_max_us),
  .out_sample_count(out_sample_count)
);

`default_nettype wire

@@ verif/running_min_max_mean_stddev_tb.sv @@
// ----------------------------------------------------------------------------
// running_min_max_mean_stddev_tb
// Sends add, report, clear and unused-code beats to the round-trip-time
// statistics block. Every report beat is checked against a local predictor
// of min, floor mean, max, deviation and count, or a fixed row's typed report.
// Directed cases, then random traffic with idle bursts, then with no idling.
// ----------------------------------------------------------------------------
module running_min_max_mean_stddev_tb;
  import rmmms_pkg::*;

  localparam int SAMPLE_W = 24;
  localparam int COUNT_W  = 16;
  localparam int VAL_W    = SAMPLE_W - 1;
  localparam int VAL_MAX  = (1 << VAL_W) - 1;
  localparam logic [COUNT_W-1:0] COUNT_FULL = '1;
  // the fourth command code is decoded as a no-op
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  // settle margin after the longest report and its result beat
  localparam int SETTLE_CYCLES = 150;

  typedef struct packed {
    logic [VAL_W-1:0]   min_us;
    logic [VAL_W-1:0]   avg_us;
    logic [VAL_W-1:0]   max_us;
    logic [VAL_W-1:0]   mdev_us;
    logic [COUNT_W-1:0] sample_count;
  } report_t;

  // one command beat; fixed rows may carry their own expected report
  typedef struct {
    logic [MODE_W-1:0]          mode;
    logic signed [SAMPLE_W-1:0] sample;
    bit                         fixed;
    bit                         has_rep;
    report_t                    rep;
  } beat_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [MODE_W-1:0]             in_mode = '0;
  logic signed [SAMPLE_W-1:0]    in_sample_us = '0;
  logic                          out_valid;
  logic [VAL_W-1:0]              out_min_us;
  logic [VAL_W-1:0]              out_avg_us;
  logic [VAL_W-1:0]              out_max_us;
  logic [VAL_W-1:0]              out_mdev_us;
  logic [COUNT_W-1:0]            out_sample_count;

  // predictor state
  logic [VAL_W-1:0]   rtt_lo;
  logic [VAL_W-1:0]   rtt_hi;
  logic [39:0]        rtt_sum;
  logic [62:0]        rtt_sumsq;
  logic [COUNT_W-1:0] rtt_n;

  report_t report_q [$];
  report_t due_rep;
  int      fail_count = 0;

  localparam report_t NO_REP = '0;

  // directed cases; expected reports typed in only where obvious
  beat_t dir_tab [0:24] = '{
    '{MODE_REPORT, 0,        1, 0, NO_REP},     // report with nothing taken
    '{MODE_ADD,    -1,       0, 0, NO_REP},     // negative sample dropped
    '{MODE_ADD,    -8388608, 0, 0, NO_REP},     // most negative sample dropped
    '{MODE_UNUSED, 12345,    0, 0, NO_REP},
    '{MODE_REPORT, 0,        1, 0, NO_REP},     // still empty
    '{MODE_ADD,    8388607,  0, 0, NO_REP},
    '{MODE_REPORT, 0,        1, 1, '{23'd8388607, 23'd8388607, 23'd8388607, 23'd0, 16'd1}},
    '{MODE_ADD,    0,        0, 0, NO_REP},
    '{MODE_REPORT, -1,       0, 0, NO_REP},
    '{MODE_CLEAR,  8388607,  0, 0, NO_REP},
    '{MODE_REPORT, 0,        1, 0, NO_REP},     // empty after clear
    '{MODE_ADD,    0,        0, 0, NO_REP},
    '{MODE_REPORT, 0,        1, 1, '{23'd0, 23'd0, 23'd0, 23'd0, 16'd1}},
    '{MODE_ADD,    100,      0, 0, NO_REP},
    '{MODE_ADD,    300,      0, 0, NO_REP},
    '{MODE_ADD,    -5,       0, 0, NO_REP},
    '{MODE_UNUSED, -1,       0, 0, NO_REP},
    '{MODE_REPORT, 0,        0, 0, NO_REP},
    '{MODE_CLEAR,  -1,       0, 0, NO_REP},
    '{MODE_ADD,    1,        0, 0, NO_REP},     // first sample after clear
    '{MODE_REPORT, 0,        1, 1, '{23'd1, 23'd1, 23'd1, 23'd0, 16'd1}},
    '{MODE_ADD,    8388607,  0, 0, NO_REP},
    '{MODE_ADD,    4194304,  0, 0, NO_REP},
    '{MODE_REPORT, 0,        0, 0, NO_REP},
    '{MODE_CLEAR,  0,        0, 0, NO_REP}
  };

  running_min_max_mean_stddev #(
    .SAMPLE_BITS(SAMPLE_W),
    .COUNT_BITS (COUNT_W)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_sample_us    (in_sample_us),
    .out_valid       (out_valid),
    .out_min_us      (out_min_us),
    .out_avg_us      (out_avg_us),
    .out_max_us      (out_max_us),
    .out_mdev_us     (out_mdev_us),
    .out_sample_count(out_sample_count)
  );

  always #5 clk = ~clk;

  // floor square root, one result bit per step from the top
  function automatic logic [31:0] floor_root(input logic [63:0] x);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if ({32'd0, trial} * {32'd0, trial} <= x) root = trial;
    end
    return root;
  endfunction

  // apply one command to the running stats; returns 1 if a report is due
  function automatic bit stats_apply(input logic [MODE_W-1:0] m,
                                     input logic signed [SAMPLE_W-1:0] s,
                                     output report_t r);
    logic [63:0] v;
    logic [63:0] mean;
    logic [63:0] mean_sq;
    logic [63:0] sq_mean;
    logic [63:0] spread;
    r = '0;
    stats_apply = 1'b0;
    v = 64'(s[VAL_W-1:0]);
    case (m)
      MODE_ADD: begin
        if (!s[SAMPLE_W-1] && rtt_n != COUNT_FULL) begin
          if (rtt_n == '0) begin
            rtt_lo = v[VAL_W-1:0];
            rtt_hi = v[VAL_W-1:0];
          end else begin
            if (v[VAL_W-1:0] < rtt_lo) rtt_lo = v[VAL_W-1:0];
            if (v[VAL_W-1:0] > rtt_hi) rtt_hi = v[VAL_W-1:0];
          end
          rtt_sum   = rtt_sum + v[39:0];
          rtt_sumsq = rtt_sumsq + 63'(v * v);
          rtt_n     = rtt_n + 1'b1;
        end
      end
      MODE_REPORT: begin
        if (rtt_n != '0) begin
          mean    = 64'(rtt_sum) / 64'(rtt_n);
          sq_mean = 64'(rtt_sumsq) / 64'(rtt_n);
          mean_sq = mean * mean;
          spread  = (sq_mean > mean_sq) ? sq_mean - mean_sq : 64'd0;
          r.min_us       = rtt_lo;
          r.avg_us       = mean[VAL_W-1:0];
          r.max_us       = rtt_hi;
          r.mdev_us      = VAL_W'(floor_root(spread));
          r.sample_count = rtt_n;
          stats_apply = 1'b1;
        end
      end
      MODE_CLEAR: begin
        rtt_lo    = '0;
        rtt_hi    = '0;
        rtt_sum   = '0;
        rtt_sumsq = '0;
        rtt_n     = '0;
      end
      default: ;
    endcase
  endfunction

  // present one beat and hold it until taken; call right after a rising edge
  task automatic drive_beat(input beat_t b);
    report_t r;
    bit      due;
    start        <= 1'b1;
    in_mode      <= b.mode;
    in_sample_us <= b.sample;
    do @(posedge clk); while (busy);
    due = stats_apply(b.mode, b.sample, r);
    if (b.fixed) begin
      due = b.has_rep;
      r   = b.rep;
    end
    if (due) report_q.push_back(r);
  endtask

  // idle burst with junk on the command lines
  task automatic idle_burst(input int n);
    start        <= 1'b0;
    in_mode      <= MODE_W'($urandom_range(0, 3));
    in_sample_us <= SAMPLE_W'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // hold off until every outstanding report has come back
  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (report_q.size() != 0);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 9))
      0, 1, 2: s = SAMPLE_W'($urandom);            // any pattern, half negative
      3, 4, 5: s = SAMPLE_W'($urandom_range(0, 255));
      6:       s = SAMPLE_W'(VAL_MAX - $urandom_range(0, 1023));
      7:       s = SAMPLE_W'(32'd1 << $urandom_range(0, VAL_W - 1));
      default: s = SAMPLE_W'($urandom_range(0, VAL_MAX));
    endcase
    return s;
  endfunction

  // random commands; counts all beats but unused codes and negative adds
  task automatic random_traffic(input int target, input bit gaps);
    beat_t b;
    int    taken;
    int    roll;
    taken = 0;
    b.fixed   = 1'b0;
    b.has_rep = 1'b0;
    b.rep     = '0;
    while (taken < target) begin
      roll     = $urandom_range(0, 99);
      b.sample = pick_sample();
      if (roll < 70)      b.mode = MODE_ADD;
      else if (roll < 88) b.mode = MODE_REPORT;
      else if (roll < 91) b.mode = MODE_CLEAR;
      else                b.mode = MODE_UNUSED;
      drive_beat(b);
      if (!(b.mode == MODE_UNUSED || (b.mode == MODE_ADD && b.sample < 0)))
        taken++;
      if (gaps && $urandom_range(0, 4) == 0) idle_burst($urandom_range(1, 15));
      if (gaps && $urandom_range(0, 149) == 0) hold_until_drained();
    end
  endtask

  function automatic void check_field(input string what, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // report beat checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (report_q.size() == 0) begin
        $display("%0t: report beat with none expected, actual min %0d avg %0d max %0d",
                 $time, out_min_us, out_avg_us, out_max_us);
        fail_count++;
      end else begin
        due_rep = report_q.pop_front();
        check_field("min_us", due_rep.min_us, out_min_us);
        check_field("avg_us", due_rep.avg_us, out_avg_us);
        check_field("max_us", due_rep.max_us, out_max_us);
        check_field("mdev_us", due_rep.mdev_us, out_mdev_us);
        check_field("sample_count", due_rep.sample_count, out_sample_count);
      end
    end
  end

  // watchdog
  initial begin
    #30_000_000;
    $display("[running_min_max_mean_stddev] ERROR");
    $finish;
  end

  // main sequence
  initial begin
    rtt_lo    = '0;
    rtt_hi    = '0;
    rtt_sum   = '0;
    rtt_sumsq = '0;
    rtt_n     = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) drive_beat(dir_tab[i]);
    hold_until_drained();

    random_traffic(800, 1'b1);
    hold_until_drained();

    random_traffic(150, 1'b0);

    start <= 1'b0;
    for (int w = 0; w < 5000 && report_q.size() != 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (report_q.size() != 0) begin
      $display("%0t: %0d expected report beats never arrived", $time, report_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[running_min_max_mean_stddev] OK");
    end else begin
      $display("[running_min_max_mean_stddev] ERROR");
    end
    $finish;
  end

endmodule
